@@ rtl/tbc_pkg.sv @@
// shared types, widths and helpers for the triangle barycentric unit
package tbc_pkg;

  // coordinate and intermediate widths
  localparam int unsigned CoordW = 16;
  localparam int unsigned EdgeW  = CoordW + 1;    // difference of two coordinates
  localparam int unsigned ProdW  = 2 * EdgeW;     // product of a pair of edge components
  localparam int unsigned CrossW = ProdW + 1;     // difference of two products
  localparam int unsigned MagW   = CrossW - 1;    // magnitude of a cross product
  localparam int unsigned FracW  = 16;            // Q16.16 fraction bits
  localparam int unsigned NumW   = MagW + FracW + 1;  // (|n| << 17) + |d|
  localparam int unsigned DenW   = MagW + 1;      // 2 * |d|
  localparam int unsigned SumW   = NumW + 5;      // room for 1 - v - w
  localparam int unsigned WeightW = 32;
  localparam int unsigned CfgIdxW = 3;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } cfg_reg_e;

  // triangle vertices as held in configuration
  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
  } tri_t;

  // divide requests leaving the setup pipeline
  typedef struct packed {
    logic [NumW-1:0] num_v;
    logic [NumW-1:0] num_w;
    logic [DenW-1:0] den;
    logic            neg_v;
    logic            neg_w;
    logic            degen;
  } div_req_t;

  // saturate a wide signed value to 32 bits
  function automatic logic [WeightW-1:0] sat32(input logic signed [SumW-1:0] x);
    logic [WeightW-1:0] r;
    if ((&x[SumW-1:WeightW-1]) || !(|x[SumW-1:WeightW-1])) begin
      r = x[WeightW-1:0];
    end else if (x[SumW-1]) begin
      r = {1'b1, {(WeightW-1){1'b0}}};
    end else begin
      r = {1'b0, {(WeightW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/tbc_if.sv @@
// point and weight channel interfaces
interface tbc_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [tbc_pkg::CoordW-1:0]   point_x;
  logic signed [tbc_pkg::CoordW-1:0]   point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface tbc_weight_if;
  logic                                valid;
  logic                                ready;
  logic signed [tbc_pkg::WeightW-1:0]  weight_b;
  logic signed [tbc_pkg::WeightW-1:0]  weight_c;
  logic signed [tbc_pkg::WeightW-1:0]  weight_a;
  logic                                degenerate;

  modport source (output valid, output weight_b, output weight_c, output weight_a,
                  output degenerate, input ready);
  modport sink   (input valid, input weight_b, input weight_c, input weight_a,
                  input degenerate, output ready);
endinterface

@@ rtl/tbc_setup.sv @@
// edge, cross product and divide operand pipeline (four stages)
module tbc_setup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [tbc_pkg::CoordW-1:0] point_x_i,
  input  logic signed [tbc_pkg::CoordW-1:0] point_y_i,
  input  tbc_pkg::tri_t                 tri_i,
  output logic                          valid_o,
  output tbc_pkg::div_req_t             req_o
);
  import tbc_pkg::*;

  logic signed [EdgeW-1:0]  e0x, e0y, e1x, e1y;
  logic signed [EdgeW-1:0]  e2x_q, e2y_q;
  logic signed [ProdW-1:0]  pd0_q, pd1_q, pv0_q, pv1_q, pw0_q, pw1_q;
  logic signed [CrossW-1:0] den_q, nv_q, nw_q;
  logic [MagW-1:0]          mag_d, mag_v, mag_w;
  logic [3:0]               vld_q;
  div_req_t                 req_q;

  // fixed edges; the user must change the configuration only while idle, the block does not enforce it
  assign e0x = $signed({tri_i.b_x[CoordW-1], tri_i.b_x}) - $signed({tri_i.a_x[CoordW-1], tri_i.a_x});
  assign e0y = $signed({tri_i.b_y[CoordW-1], tri_i.b_y}) - $signed({tri_i.a_y[CoordW-1], tri_i.a_y});
  assign e1x = $signed({tri_i.c_x[CoordW-1], tri_i.c_x}) - $signed({tri_i.a_x[CoordW-1], tri_i.a_x});
  assign e1y = $signed({tri_i.c_y[CoordW-1], tri_i.c_y}) - $signed({tri_i.a_y[CoordW-1], tri_i.a_y});

  // magnitudes of the cross products
  assign mag_d = den_q[CrossW-1] ? MagW'(-den_q) : MagW'(den_q);
  assign mag_v = nv_q[CrossW-1]  ? MagW'(-nv_q)  : MagW'(nv_q);
  assign mag_w = nw_q[CrossW-1]  ? MagW'(-nw_q)  : MagW'(nw_q);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // offset of the query point
      e2x_q <= $signed({point_x_i[CoordW-1], point_x_i}) - $signed({tri_i.a_x[CoordW-1], tri_i.a_x});
      e2y_q <= $signed({point_y_i[CoordW-1], point_y_i}) - $signed({tri_i.a_y[CoordW-1], tri_i.a_y});
      // products
      pd0_q <= e0x * e1y;
      pd1_q <= e0y * e1x;
      pv0_q <= e2x_q * e1y;
      pv1_q <= e2y_q * e1x;
      pw0_q <= e0x * e2y_q;
      pw1_q <= e0y * e2x_q;
      // cross products
      den_q <= $signed({pd0_q[ProdW-1], pd0_q}) - $signed({pd1_q[ProdW-1], pd1_q});
      nv_q  <= $signed({pv0_q[ProdW-1], pv0_q}) - $signed({pv1_q[ProdW-1], pv1_q});
      nw_q  <= $signed({pw0_q[ProdW-1], pw0_q}) - $signed({pw1_q[ProdW-1], pw1_q});
      // rounding divide operands: (2|n|*2^16 + |d|) / (2|d|)
      req_q.num_v <= {mag_v, {(FracW+1){1'b0}}} + {{(FracW+1){1'b0}}, mag_d};
      req_q.num_w <= {mag_w, {(FracW+1){1'b0}}} + {{(FracW+1){1'b0}}, mag_d};
      req_q.den   <= {mag_d, 1'b0};
      req_q.neg_v <= nv_q[CrossW-1] ^ den_q[CrossW-1];
      req_q.neg_w <= nw_q[CrossW-1] ^ den_q[CrossW-1];
      req_q.degen <= (den_q == '0);
    end
  end

  assign valid_o = vld_q[3];
  assign req_o   = req_q;

endmodule

@@ rtl/tbc_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
module tbc_divider #(
  parameter int unsigned TagW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [tbc_pkg::NumW-1:0]    num_i,
  input  logic [tbc_pkg::DenW-1:0]    den_i,
  input  logic [TagW-1:0]             tag_i,
  output logic                        valid_o,
  output logic [tbc_pkg::NumW-1:0]    quot_o,
  output logic [TagW-1:0]             tag_o
);
  import tbc_pkg::*;

  logic [NumW-1:0] num_q  [1:NumW];
  logic [NumW-1:0] quot_q [1:NumW];
  logic [DenW-1:0] rem_q  [1:NumW];
  logic [DenW-1:0] den_q  [1:NumW];
  logic [TagW-1:0] tag_q  [1:NumW];
  logic            vld_q  [1:NumW];

  for (genvar k = 1; k <= NumW; k++) begin : g_stage
    logic [NumW-1:0] num_p, quot_p;
    logic [DenW-1:0] rem_p, den_p;
    logic [TagW-1:0] tag_p;
    logic            vld_p;
    logic [DenW:0]   rem_sh;
    logic            ge;

    if (k == 1) begin : g_first
      assign num_p  = num_i;
      assign quot_p = '0;
      assign rem_p  = '0;
      assign den_p  = den_i;
      assign tag_p  = tag_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign num_p  = num_q[k-1];
      assign quot_p = quot_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign den_p  = den_q[k-1];
      assign tag_p  = tag_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    // bring down the next numerator bit and try the subtract
    assign rem_sh = {rem_p, num_p[NumW-1]};
    assign ge     = (rem_sh >= {1'b0, den_p});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DenW'(rem_sh - {1'b0, den_p}) : DenW'(rem_sh);
        num_q[k]  <= {num_p[NumW-2:0], 1'b0};
        quot_q[k] <= {quot_p[NumW-2:0], ge};
        den_q[k]  <= den_p;
        tag_q[k]  <= tag_p;
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quot_o  = quot_q[NumW];
  assign tag_o   = tag_q[NumW];

endmodule

@@ rtl/triangle_barycentric_coords_unit.sv @@
// barycentric weights of a query point against a configured 2d triangle
//
// Usage: write the six vertex coordinates (A, B, C; signed Q12.4) through
// the configuration port while no transaction is in flight. Each
// transaction on point_i carries one query point; each transaction on
// weight_o returns the weights of B, C and A (signed Q16.16, saturated)
// and a degenerate flag, in the order the points arrived.
// The pipeline has four setup stages (offset, products, cross
// products, divide operands), 51 divider stages that each settle one
// quotient bit, and the output register. One point is taken per cycle
// while weight_o is ready; the divider is fully pipelined, so throughput
// is one transaction per cycle while weight_o is ready.
// Reset clears the vertices to zero and empties the pipeline.
// When the receiver stalls, the whole pipeline holds in place and
// point_i.ready drops, so nothing is lost or repeated.
module triangle_barycentric_coords_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tbc_pkg::CoordW-1:0]     cfg_data_i,
  tbc_point_if.sink                      point_i,
  tbc_weight_if.source                   weight_o
);
  import tbc_pkg::*;

  tri_t                tri_q;
  logic                en;
  logic                setup_vld;
  div_req_t            req;
  logic                vld_v, vld_w;
  logic [NumW-1:0]     quot_v, quot_w;
  logic [1:0]          tag_v;
  logic                tag_w;
  logic signed [SumW-1:0] sv, sw, su;
  logic                out_vld_q;
  logic [WeightW-1:0]  wb_q, wc_q, wa_q;
  logic                degen_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A_X: tri_q.a_x <= cfg_data_i;
        REG_A_Y: tri_q.a_y <= cfg_data_i;
        REG_B_X: tri_q.b_x <= cfg_data_i;
        REG_B_Y: tri_q.b_y <= cfg_data_i;
        REG_C_X: tri_q.c_x <= cfg_data_i;
        REG_C_Y: tri_q.c_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register can be emptied
  assign en            = !out_vld_q || weight_o.ready;
  assign point_i.ready = en;

  tbc_setup u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (point_i.valid),
    .point_x_i (point_i.point_x),
    .point_y_i (point_i.point_y),
    .tri_i     (tri_q),
    .valid_o   (setup_vld),
    .req_o     (req)
  );

  tbc_divider #(.TagW(2)) u_div_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (setup_vld),
    .num_i   (req.num_v),
    .den_i   (req.den),
    .tag_i   ({req.degen, req.neg_v}),
    .valid_o (vld_v),
    .quot_o  (quot_v),
    .tag_o   (tag_v)
  );

  tbc_divider #(.TagW(1)) u_div_w (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (setup_vld),
    .num_i   (req.num_w),
    .den_i   (req.den),
    .tag_i   (req.neg_w),
    .valid_o (vld_w),
    .quot_o  (quot_w),
    .tag_o   (tag_w)
  );

  // signed weights and the weight of A
  assign sv = tag_v[0] ? -$signed({{(SumW-NumW){1'b0}}, quot_v})
                       :  $signed({{(SumW-NumW){1'b0}}, quot_v});
  assign sw = tag_w ? -$signed({{(SumW-NumW){1'b0}}, quot_w})
                    :  $signed({{(SumW-NumW){1'b0}}, quot_w});
  assign su = $signed(SumW'(1) << FracW) - sv - sw;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_v & vld_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_v) begin
      degen_q <= tag_v[1];
      wb_q    <= tag_v[1] ? '0 : sat32(sv);
      wc_q    <= tag_v[1] ? '0 : sat32(sw);
      wa_q    <= tag_v[1] ? '0 : sat32(su);
    end
  end

  assign weight_o.valid      = out_vld_q;
  assign weight_o.weight_b   = wb_q;
  assign weight_o.weight_c   = wc_q;
  assign weight_o.weight_a   = wa_q;
  assign weight_o.degenerate = degen_q;

endmodule

@@ rtl/tbc_checker.sv @@
// port level checks for the barycentric unit and their binding
module tbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] weight_b_i,
  input logic [31:0] weight_c_i,
  input logic [31:0] weight_a_i,
  input logic        degenerate_i
);

  // a degenerate triangle gives zero weights
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |->
      weight_b_i == '0 && weight_c_i == '0 && weight_a_i == '0)
    else $error("degenerate result with nonzero weights");

  // small weights sum to one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !degenerate_i &&
    (weight_b_i[31:29] == 3'b000 || weight_b_i[31:29] == 3'b111) &&
    (weight_c_i[31:29] == 3'b000 || weight_c_i[31:29] == 3'b111) |->
      weight_a_i == 32'(32'h0001_0000 - weight_b_i - weight_c_i))
    else $error("weights do not sum to one");

  // input side is open whenever the output register can drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled although the output is free");

  // a stalled transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(weight_b_i) && $stable(weight_c_i) &&
      $stable(weight_a_i) && $stable(degenerate_i))
    else $error("stalled result changed");

endmodule

bind triangle_barycentric_coords_unit tbc_checker u_tbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (point_i.ready),
  .out_valid_i  (weight_o.valid),
  .out_ready_i  (weight_o.ready),
  .weight_b_i   (weight_o.weight_b),
  .weight_c_i   (weight_o.weight_c),
  .weight_a_i   (weight_o.weight_a),
  .degenerate_i (weight_o.degenerate)
);

@@ tb/sv/tbc_checker.sv @@
// transaction monitor, weight prediction and comparison for the barycentric unit
`timescale 1ns / 1ps

module tbc_scoreboard (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tbc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tbc_pkg::CoordW-1:0]  cfg_data_i,
  tbc_point_if                        point_i,
  tbc_weight_if                       weight_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import tbc_pkg::*;

  typedef struct packed {
    logic [WeightW-1:0] weight_b;
    logic [WeightW-1:0] weight_c;
    logic [WeightW-1:0] weight_a;
    logic               degenerate;
  } weights_t;

  tri_t     verts_q;
  weights_t weights_due_q[$];

  // rounded quotient num * 2^16 / den, ties away from zero
  function automatic longint q16_quotient(input longint num, input longint den);
    logic            neg;
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    neg = (num < 0) != (den < 0);
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    q   = ((n << 17) + d) / (d << 1);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [WeightW-1:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[WeightW-1:0];
  endfunction

  // barycentric weights of point p against the held triangle
  function automatic weights_t barycentric(input tri_t t, input logic signed [15:0] px,
                                           input logic signed [15:0] py);
    longint   e0x, e0y, e1x, e1y, e2x, e2y, den, nv, nw, v, w;
    weights_t r;
    e0x = longint'(t.b_x) - longint'(t.a_x);
    e0y = longint'(t.b_y) - longint'(t.a_y);
    e1x = longint'(t.c_x) - longint'(t.a_x);
    e1y = longint'(t.c_y) - longint'(t.a_y);
    e2x = longint'(px) - longint'(t.a_x);
    e2y = longint'(py) - longint'(t.a_y);
    den = e0x * e1y - e0y * e1x;
    nv  = e2x * e1y - e2y * e1x;
    nw  = e0x * e2y - e0y * e2x;
    if (den == 0) begin
      r = '0;
      r.degenerate = 1'b1;
    end else begin
      v = q16_quotient(nv, den);
      w = q16_quotient(nw, den);
      r.weight_b   = clip32(v);
      r.weight_c   = clip32(w);
      r.weight_a   = clip32(64'sd65536 - v - w);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  // vertex registers as seen on the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verts_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A_X: verts_q.a_x <= cfg_data_i;
        REG_A_Y: verts_q.a_y <= cfg_data_i;
        REG_B_X: verts_q.b_x <= cfg_data_i;
        REG_B_Y: verts_q.b_y <= cfg_data_i;
        REG_C_X: verts_q.c_x <= cfg_data_i;
        REG_C_Y: verts_q.c_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // predict on point transactions, compare on weight transactions
  always @(posedge clk_i) begin
    weights_t exp_w;
    if (!rst_ni) begin
      fail_count_o = 0;
    end else begin
      if (point_i.valid && point_i.ready)
        weights_due_q.push_back(barycentric(verts_q, point_i.point_x, point_i.point_y));
      if (weight_i.valid && weight_i.ready) begin
        if (weights_due_q.size() == 0) begin
          $error("weight transaction with no point outstanding");
          fail_count_o++;
        end else begin
          exp_w = weights_due_q.pop_front();
          if (weight_i.weight_b !== exp_w.weight_b) begin
            $error("weight_b expected %h actual %h", exp_w.weight_b, weight_i.weight_b);
            fail_count_o++;
          end
          if (weight_i.weight_c !== exp_w.weight_c) begin
            $error("weight_c expected %h actual %h", exp_w.weight_c, weight_i.weight_c);
            fail_count_o++;
          end
          if (weight_i.weight_a !== exp_w.weight_a) begin
            $error("weight_a expected %h actual %h", exp_w.weight_a, weight_i.weight_a);
            fail_count_o++;
          end
          if (weight_i.degenerate !== exp_w.degenerate) begin
            $error("degenerate expected %b actual %b", exp_w.degenerate,
                   weight_i.degenerate);
            fail_count_o++;
          end
        end
      end
    end
  end

  assign pending_o = weights_due_q.size();
endmodule

@@ tb/sv/tb.sv @@
// top-level stimulus and verdict for the triangle barycentric unit
`timescale 1ns / 1ps

module tb;
  import tbc_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;
  localparam int Limit = 400000;
  localparam int DrainCycles = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CoordW-1:0]  cfg_data_i = '0;
  int                 fail_count;
  int                 pending;
  int                 cycle_cnt = 0;
  bit                 sink_stalls = 1'b1;
  bit                 src_gaps = 1'b1;
  logic signed [15:0] tri_v[6];

  tbc_point_if  pt_if();
  tbc_weight_if wt_if();

  initial begin
    pt_if.valid   = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    wt_if.ready   = 1'b0;
  end

  triangle_barycentric_coords_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .point_i(pt_if), .weight_o(wt_if)
  );

  tbc_scoreboard u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .point_i(pt_if), .weight_i(wt_if),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > Limit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 5);
    return $urandom_range(2);
  endfunction

  // receiver ready with stalls of random length
  initial begin
    int n;
    forever begin
      n = sink_stalls ? gap_len() : 0;
      if (n > 0) begin
        @(posedge clk_i) wt_if.ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end
      repeat ($urandom_range(12, 1)) @(posedge clk_i) wt_if.ready <= 1'b1;
    end
  end

  function automatic logic signed [15:0] rand_between(input int lo, input int hi);
    if (hi < lo) return 16'(lo);
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // one point transaction, then an optional gap
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
    bit ok;
    int n;
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= x;
    pt_if.point_y <= y;
    do begin
      @(negedge clk_i);
      ok = pt_if.ready;
      @(posedge clk_i);
    end while (!ok);
    n = src_gaps ? gap_len() : 0;
    if (n > 0) begin
      pt_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // let every transaction drain, then wait out the DrainCycles margin
  task automatic wait_idle();
    pt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // vertex burst, with writes to the unused indexes mixed in
  task automatic write_tri(input int ax, ay, bx, by, cx, cy);
    logic [CfgIdxW-1:0] idx[8];
    logic [15:0]        val[8];
    idx = '{REG_A_X, REG_A_Y, RegSpare6, REG_B_X, REG_B_Y, REG_C_X, RegSpare7, REG_C_Y};
    val = '{16'(ax), 16'(ay), 16'($urandom), 16'(bx), 16'(by), 16'(cx),
            16'($urandom), 16'(cy)};
    tri_v = '{16'(ax), 16'(ay), 16'(bx), 16'(by), 16'(cx), 16'(cy)};
    foreach (idx[i]) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
    end
    @(posedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // mostly points in the triangle's bounding box, some anywhere
  task automatic random_points(input int count);
    int lox, hix, loy, hiy;
    lox = tri_v[0]; hix = tri_v[0]; loy = tri_v[1]; hiy = tri_v[1];
    for (int k = 1; k < 3; k++) begin
      if (tri_v[2*k] < lox) lox = tri_v[2*k];
      if (tri_v[2*k] > hix) hix = tri_v[2*k];
      if (tri_v[2*k+1] < loy) loy = tri_v[2*k+1];
      if (tri_v[2*k+1] > hiy) hiy = tri_v[2*k+1];
    end
    repeat (count) begin
      if ($urandom_range(9) < 6)
        send_point(rand_between(lox, hix), rand_between(loy, hiy));
      else
        send_point(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic directed_points();
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh7fff);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh0000, 16'sh0000);
    send_point(16'shffff, 16'sh5555);
    for (int k = 0; k < 3; k++) send_point(tri_v[2*k], tri_v[2*k+1]);
  endtask

  initial begin
    int ax, ay, bx, by, cx, cy, mode;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset triangle is all zero and hence degenerate
    tri_v = '{default: 0};
    directed_points();
    wait_idle();

    // unit right triangle of one pixel
    write_tri(0, 0, 16, 0, 0, 16);
    directed_points();
    send_point(16'sd5, 16'sd5);
    wait_idle();

    // largest triangle the coordinates allow
    write_tri(-32768, -32768, 32767, -32768, -32768, 32767);
    directed_points();
    wait_idle();

    // collinear vertices
    write_tri(-100, -100, 0, 0, 32767, 32767);
    directed_points();
    wait_idle();

    // tiny triangle, far points saturate the weights
    write_tri(1, 0, 0, 1, 0, 0);
    directed_points();
    wait_idle();

    // random triangles: wide, small, degenerate
    for (int ph = 0; ph < 10; ph++) begin
      mode = $urandom_range(9);
      sink_stalls = (ph % 4) != 3;
      src_gaps    = (ph % 5) != 4;
      ax = 16'($urandom); ax = 32'(signed'(16'(ax)));
      ay = 16'($urandom); ay = 32'(signed'(16'(ay)));
      if (mode < 5) begin
        bx = rand_between(-32768, 32767); by = rand_between(-32768, 32767);
        cx = rand_between(-32768, 32767); cy = rand_between(-32768, 32767);
      end else if (mode < 8) begin
        ax = rand_between(-2000, 2000); ay = rand_between(-2000, 2000);
        bx = ax + rand_between(-64, 64); by = ay + rand_between(-64, 64);
        cx = ax + rand_between(-64, 64); cy = ay + rand_between(-64, 64);
      end else begin
        ax = rand_between(-1000, 1000); ay = rand_between(-1000, 1000);
        bx = ax + rand_between(-300, 300); by = ay + rand_between(-300, 300);
        cx = ax + 2 * (bx - ax); cy = ay + 2 * (by - ay);
      end
      write_tri(ax, ay, bx, by, cx, cy);
      random_points(80);
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
